// File: sv/bcse_pkg.sv
// ----------------------------------------------------------------------------
// bcse_pkg
// Shared constant for the Bezier curve segment evaluator.
// ----------------------------------------------------------------------------
package bcse_pkg;

    localparam int BCSE_FRACTION_BITS = 16;

endpackage

// File: sv/bcse_sqrt_cell.sv
// ----------------------------------------------------------------------------
// bcse_sqrt_cell
// One digit step of the integer square root, with its own pipeline register.
// ----------------------------------------------------------------------------
module bcse_sqrt_cell #(
    parameter int W     = 34,
    parameter int SBW   = 8,
    parameter int SHIFT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [W-1:0]   i_n,
    input  logic [W-1:0]   i_res,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic [W-1:0]   o_n,
    output logic [W-1:0]   o_res,
    output logic [SBW-1:0] o_side
);

    localparam logic [W-1:0] BIT = W'(1) << SHIFT;

    logic           r_valid;
    logic [W-1:0]   r_n;
    logic [W-1:0]   r_res;
    logic [SBW-1:0] r_side;
    logic [W-1:0]   trial;
    logic           ge;
    logic [W-1:0]   n_n;
    logic [W-1:0]   n_res;

    always_comb begin
        trial = i_res + BIT;
        ge    = (i_n >= trial);
        n_n   = ge ? (i_n - trial) : i_n;
        n_res = ge ? ((i_res >> 1) + BIT) : (i_res >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_n    <= n_n;
            r_res  <= n_res;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_res   = r_res;
    assign o_side  = r_side;

endmodule

// File: sv/bcse_div_cell.sv
// ----------------------------------------------------------------------------
// bcse_div_cell
// One restoring division step producing one quotient bit, registered.
// ----------------------------------------------------------------------------
module bcse_div_cell #(
    parameter int DW  = 18,
    parameter int NW  = 34,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [DW-1:0]  i_rem,
    input  logic [NW-1:0]  i_num,
    input  logic [NW-1:0]  i_quo,
    input  logic [DW-1:0]  i_den,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic [DW-1:0]  o_rem,
    output logic [NW-1:0]  o_num,
    output logic [NW-1:0]  o_quo,
    output logic [DW-1:0]  o_den,
    output logic [SBW-1:0] o_side
);

    logic           r_valid;
    logic [DW-1:0]  r_rem;
    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_quo;
    logic [DW-1:0]  r_den;
    logic [SBW-1:0] r_side;
    logic [DW-1:0]  trial;
    logic           ge;

    always_comb begin
        trial = {i_rem[DW-2:0], i_num[NW-1]};
        ge    = (trial >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rem  <= ge ? (trial - i_den) : trial;
            r_num  <= i_num << 1;
            r_quo  <= {i_quo[NW-2:0], ge};
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

// File: sv/bezier_curve_segment_eval.sv
// ----------------------------------------------------------------------------
// bezier_curve_segment_eval
// Evaluates a straight or quadratic Bezier automation segment at a position.
// ----------------------------------------------------------------------------
// Each request on the slave side carries position, start value, end value,
// handle time and handle offset; each request on the master side carries the
// curve value. One request is accepted per clock cycle when the master side
// is not stalled. Results leave in request order.
// Each request passes through three front stages, one square root cell per
// result bit (FRACTION_BITS+1 cells), one stage forming the divisor, one
// division cell per quotient bit (2*FRACTION_BITS+2 cells) and five back
// stages ending in the output register. Throughput is one request per cycle
// when the master side is not stalled.
// The whole row of cells advances together: when the output register holds
// a result that the receiver does not take, o_s_tready falls and every stage
// holds its contents. Reset clears all stage valid bits, so no result is
// presented until a new request has gone through the row.
// ----------------------------------------------------------------------------
module bezier_curve_segment_eval #(
    parameter int FRACTION_BITS = bcse_pkg::BCSE_FRACTION_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // position, start_value, end_value, handle_time, handle_offset, zero pad
    input  logic [((5*FRACTION_BITS+13)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // curve_value, zero pad
    output logic [((FRACTION_BITS+8)/8)*8-1:0] o_m_tdata
);

    import bcse_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int UW  = F + 1;
    localparam int SW  = F + 2;
    localparam int CW  = F + 5;
    localparam int PW  = 2 * F + 4;
    localparam int RW  = 2 * F + 2;
    localparam int NQ  = F + 1;
    localparam int DW  = F + 2;
    localparam int NW  = 2 * F + 2;
    localparam int MW  = 2 * F + 7;
    localparam int YW  = 2 * F + 8;
    localparam int OW  = ((F + 8) / 8) * 8;
    localparam int SBW = 1 + PW + CW + 4 * UW;

    localparam logic [UW-1:0] ONE    = UW'(1) << F;
    localparam logic [UW-1:0] HALF   = UW'(1) << (F - 1);
    localparam logic [UW-1:0] QTR    = UW'(1) << (F - 2);
    localparam logic [UW-1:0] THREEQ = UW'(3) << (F - 2);
    localparam logic signed [SW-1:0] ONE_S = SW'(1) << F;
    localparam logic signed [SW-1:0] MONE_S = -(SW'(1) << F);
    localparam logic [2*UW-1:0] RND_W = (2 * UW)'(1) << (F - 1);
    localparam logic signed [YW-1:0] Y_MAX = YW'(1) << (2 * F);
    localparam logic signed [YW-1:0] RND_Y = YW'(1) << (F - 1);

    logic en;
    assign en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // Front decode.
    logic [UW-1:0]        d_pos, d_v0, d_v1, d_ht, d_x, d_pin, d_cx;
    logic signed [SW-1:0] d_raw, d_off, d_a, d_dv;
    logic signed [CW-1:0] d_cy2;
    logic                 d_straight;
    logic [UW:0]          d_cx_w;

    always_comb begin
        d_pos = i_s_tdata[UW-1:0];
        d_v0  = i_s_tdata[2*UW-1:UW];
        d_v1  = i_s_tdata[3*UW-1:2*UW];
        d_ht  = i_s_tdata[4*UW-1:3*UW];
        d_raw = $signed(i_s_tdata[4*UW+SW-1:4*UW]);
        d_x   = (d_pos > ONE) ? ONE : d_pos;
        if (d_raw > ONE_S) begin
            d_off = ONE_S;
        end else if (d_raw < MONE_S) begin
            d_off = MONE_S;
        end else begin
            d_off = d_raw;
        end
        d_straight = (d_ht == HALF) && (d_off == '0);
        if (d_ht < QTR) begin
            d_pin = QTR;
        end else if (d_ht > THREEQ) begin
            d_pin = THREEQ;
        end else begin
            d_pin = d_ht;
        end
        d_cx_w = {d_pin, 1'b0} - {1'b0, HALF};
        d_cx   = d_cx_w[UW-1:0];
        d_a    = $signed({1'b0, ONE}) - $signed({d_cx, 1'b0});
        d_dv   = $signed({1'b0, d_v1}) - $signed({1'b0, d_v0});
        d_cy2  = $signed({4'b0000, d_v0}) + $signed({4'b0000, d_v1})
               + ($signed({{3{d_off[SW-1]}}, d_off}) <<< 2);
    end

    // Stage A.
    logic                 r_va, r_sta;
    logic [UW-1:0]        r_xa, r_v0a, r_v1a, r_cxa;
    logic signed [SW-1:0] r_aa, r_dva;
    logic signed [CW-1:0] r_cy2a;

    // Stage B.
    logic                 r_vb, r_stb;
    logic [UW-1:0]        r_xb, r_v0b, r_v1b, r_cxb;
    logic signed [CW-1:0] r_cy2b;
    logic [2*UW-1:0]      r_pcc;
    logic signed [PW-1:0] r_pax, r_pst;

    // Stage C.
    logic                 r_vc;
    logic [RW-1:0]        r_disc;
    logic [SBW-1:0]       r_sidec;
    logic signed [PW-1:0] n_disc, n_ys;

    always_comb begin
        n_disc = $signed({2'b00, r_pcc}) + r_pax;
        n_ys   = $signed({3'b000, r_v0b, {F{1'b0}}}) + r_pst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (en) begin
            r_va <= i_s_tvalid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
        if (en) begin
            r_sta  <= d_straight;
            r_xa   <= d_x;
            r_v0a  <= d_v0;
            r_v1a  <= d_v1;
            r_cxa  <= d_cx;
            r_aa   <= d_a;
            r_dva  <= d_dv;
            r_cy2a <= d_cy2;

            r_stb  <= r_sta;
            r_xb   <= r_xa;
            r_v0b  <= r_v0a;
            r_v1b  <= r_v1a;
            r_cxb  <= r_cxa;
            r_cy2b <= r_cy2a;
            r_pcc  <= r_cxa * r_cxa;
            r_pax  <= PW'(r_aa) * PW'($signed({1'b0, r_xa}));
            r_pst  <= PW'(r_dva) * PW'($signed({1'b0, r_xa}));

            r_disc  <= n_disc[RW-1:0];
            r_sidec <= {r_stb, n_ys, r_cy2b, r_v1b, r_v0b, r_xb, r_cxb};
        end
    end

    // Square root row.
    logic           sq_v [0:NQ];
    logic [RW-1:0]  sq_n [0:NQ];
    logic [RW-1:0]  sq_r [0:NQ];
    logic [SBW-1:0] sq_s [0:NQ];

    assign sq_v[0] = r_vc;
    assign sq_n[0] = r_disc;
    assign sq_r[0] = '0;
    assign sq_s[0] = r_sidec;

    for (genvar k = 0; k < NQ; k++) begin : g_sqrt
        bcse_sqrt_cell #(
            .W    (RW),
            .SBW  (SBW),
            .SHIFT(2 * (NQ - 1 - k))
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(sq_v[k]),
            .i_n    (sq_n[k]),
            .i_res  (sq_r[k]),
            .i_side (sq_s[k]),
            .o_valid(sq_v[k+1]),
            .o_n    (sq_n[k+1]),
            .o_res  (sq_r[k+1]),
            .o_side (sq_s[k+1])
        );
    end

    // Stage D: divisor and rounded dividend.
    logic [UW-1:0]        s_x, s_cx;
    logic [DW-1:0]        n_den;
    logic [NW-1:0]        n_num;

    assign s_x  = sq_s[NQ][2*UW-1:UW];
    assign s_cx = sq_s[NQ][UW-1:0];

    always_comb begin
        n_den = {1'b0, sq_r[NQ][UW-1:0]} + {1'b0, s_cx};
        n_num = {1'b0, s_x, {F{1'b0}}} + {{(NW - DW + 1){1'b0}}, n_den[DW-1:1]};
    end

    logic           r_vd;
    logic [DW-1:0]  r_dend;
    logic [NW-1:0]  r_numd;
    logic [SBW-1:0] r_sided;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (en) begin
            r_vd <= sq_v[NQ];
        end
        if (en) begin
            r_dend  <= n_den;
            r_numd  <= n_num;
            r_sided <= sq_s[NQ];
        end
    end

    // Division row.
    logic           dv_v [0:NW];
    logic [DW-1:0]  dv_r [0:NW];
    logic [NW-1:0]  dv_n [0:NW];
    logic [NW-1:0]  dv_q [0:NW];
    logic [DW-1:0]  dv_d [0:NW];
    logic [SBW-1:0] dv_s [0:NW];

    assign dv_v[0] = r_vd;
    assign dv_r[0] = '0;
    assign dv_n[0] = r_numd;
    assign dv_q[0] = '0;
    assign dv_d[0] = r_dend;
    assign dv_s[0] = r_sided;

    for (genvar k = 0; k < NW; k++) begin : g_div
        bcse_div_cell #(
            .DW (DW),
            .NW (NW),
            .SBW(SBW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(dv_v[k]),
            .i_rem  (dv_r[k]),
            .i_num  (dv_n[k]),
            .i_quo  (dv_q[k]),
            .i_den  (dv_d[k]),
            .i_side (dv_s[k]),
            .o_valid(dv_v[k+1]),
            .o_rem  (dv_r[k+1]),
            .o_num  (dv_n[k+1]),
            .o_quo  (dv_q[k+1]),
            .o_den  (dv_d[k+1]),
            .o_side (dv_s[k+1])
        );
    end

    logic                 e_st;
    logic signed [PW-1:0] e_ys;
    logic signed [CW-1:0] e_cy2;
    logic [UW-1:0]        e_v1, e_v0;
    logic [UW-1:0]        n_u;

    assign {e_st, e_ys, e_cy2, e_v1, e_v0} = dv_s[NW][SBW-1:2*UW];

    always_comb begin
        if (dv_d[NW] == '0) begin
            n_u = '0;
        end else if (dv_q[NW] > NW'(ONE)) begin
            n_u = ONE;
        end else begin
            n_u = dv_q[NW][UW-1:0];
        end
    end

    // Back stages E, F, G, H.
    logic                 r_ve, r_vf, r_vg, r_vh;
    logic                 r_ste, r_stf, r_stg, r_sth;
    logic signed [PW-1:0] r_yse, r_ysf, r_ysg, r_ysh;
    logic signed [CW-1:0] r_cye, r_cyf, r_cyg;
    logic [UW-1:0]        r_v0e, r_v0f, r_v0g, r_v1e, r_v1f, r_v1g;
    logic [UW-1:0]        r_ue, r_omue;
    logic [2*UW-1:0]      r_p0, r_p1, r_p2;
    logic [2*UW-1:0]      n_t0, n_t1, n_t2;
    logic [UW-1:0]        r_w0, r_w1, r_w2;
    logic [2*UW-1:0]      r_m0, r_m2;
    logic signed [MW-1:0] r_m1;

    always_comb begin
        n_t0 = r_p0 + RND_W;
        n_t1 = r_p1 + RND_W;
        n_t2 = r_p2 + RND_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
        end else if (en) begin
            r_ve <= dv_v[NW];
            r_vf <= r_ve;
            r_vg <= r_vf;
            r_vh <= r_vg;
        end
        if (en) begin
            r_ste  <= e_st;
            r_yse  <= e_ys;
            r_cye  <= e_cy2;
            r_v0e  <= e_v0;
            r_v1e  <= e_v1;
            r_ue   <= n_u;
            r_omue <= ONE - n_u;

            r_stf <= r_ste;
            r_ysf <= r_yse;
            r_cyf <= r_cye;
            r_v0f <= r_v0e;
            r_v1f <= r_v1e;
            r_p0  <= r_omue * r_omue;
            r_p1  <= r_omue * r_ue;
            r_p2  <= r_ue * r_ue;

            r_stg <= r_stf;
            r_ysg <= r_ysf;
            r_cyg <= r_cyf;
            r_v0g <= r_v0f;
            r_v1g <= r_v1f;
            r_w0  <= n_t0[F+UW-1:F];
            r_w1  <= n_t1[F+UW-1:F];
            r_w2  <= n_t2[F+UW-1:F];

            r_sth <= r_stg;
            r_ysh <= r_ysg;
            r_m0  <= r_w0 * r_v0g;
            r_m2  <= r_w2 * r_v1g;
            r_m1  <= MW'($signed({1'b0, r_w1})) * MW'(r_cyg);
        end
    end

    // Output stage.
    logic signed [YW-1:0] n_y, n_yc, n_yr;
    logic                 r_m_tvalid;
    logic [UW-1:0]        r_out;

    always_comb begin
        if (r_sth) begin
            n_y = YW'(r_ysh);
        end else begin
            n_y = $signed(YW'(r_m0)) + YW'(r_m1) + $signed(YW'(r_m2));
        end
        if (n_y < 0) begin
            n_yc = '0;
        end else if (n_y > Y_MAX) begin
            n_yc = Y_MAX;
        end else begin
            n_yc = n_y;
        end
        n_yr = n_yc + RND_Y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (en) begin
            r_m_tvalid <= r_vh;
        end
        if (en) begin
            r_out <= n_yr[F+UW-1:F];
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = OW'(r_out);

endmodule

// File: sv/bcse_checker.sv
// ----------------------------------------------------------------------------
// bcse_checker
// Port-level checks of the Bezier curve segment evaluator.
// ----------------------------------------------------------------------------
module bcse_checker #(
    parameter int FRACTION_BITS = bcse_pkg::BCSE_FRACTION_BITS
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic [((5*FRACTION_BITS+13)/8)*8-1:0] i_s_tdata,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [((FRACTION_BITS+8)/8)*8-1:0] o_m_tdata
);

    import bcse_pkg::*;

    localparam int OW = ((FRACTION_BITS + 8) / 8) * 8;
    localparam logic [OW-1:0] ONE = OW'(1) << FRACTION_BITS;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled result changed.");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata <= ONE)
        else $error("Curve value above one.");

    a_ready: assert property (@(posedge i_clk)
        !o_m_tvalid |-> o_s_tready)
        else $error("Request refused with an empty output register.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result shown right after reset.");

endmodule

bind bezier_curve_segment_eval bcse_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_bcse_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tdata (i_s_tdata),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

// File: tb/bezier_curve_segment_eval_tb.sv
// ----------------------------------------------------------------------------
// bezier_curve_segment_eval_tb
// Self-checking bench for the Bezier curve segment evaluator.
// ----------------------------------------------------------------------------
// Requests are queued by an initial block and driven by a clocked driver.
// Each accepted request is evaluated by a local fixed-point model of the
// segment, and the expected curve value is queued and compared against
// the master side in order. The run covers several idle and stall phases,
// a long receiver hold-off, and a drain pause.
// ----------------------------------------------------------------------------
module bezier_curve_segment_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcse_pkg::*;

    localparam int FB = BCSE_FRACTION_BITS;
    localparam int SW = ((5*FB+13)/8)*8;
    localparam int MW = ((FB+8)/8)*8;
    localparam longint ONE = longint'(1) << FB;
    localparam int LATENCY = 3*FB+12;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [FB+1:0] handle_offset;
        logic [FB:0] handle_time;
        logic [FB:0] end_value;
        logic [FB:0] start_value;
        logic [FB:0] position;
    } t_segment_req;

    localparam int RQW = $bits(t_segment_req);

    logic i_clk;
    logic i_rst_n;
    logic i_s_tvalid;
    logic o_s_tready;
    logic [SW-1:0] i_s_tdata;
    logic o_m_tvalid;
    logic i_m_tready;
    logic [MW-1:0] o_m_tdata;

    bezier_curve_segment_eval uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    t_segment_req pending_reqs[$];
    logic [FB:0] expected_values[$];
    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    bit stop_sending;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint round_q(longint v);
        return (v + (longint'(1) << (FB-1))) >>> FB;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        end
        return r;
    endfunction

    function automatic logic [FB:0] curve_value_of(t_segment_req r);
        longint x, v0, v1, ht, off, y, pin_x, cx, cy2, disc, s, den, u, omu;
        x = clamp_range(longint'(r.position), 0, ONE);
        v0 = longint'(r.start_value);
        v1 = longint'(r.end_value);
        ht = longint'(r.handle_time);
        off = clamp_range(longint'(r.handle_offset), -ONE, ONE);
        if (ht == ONE/2 && off == 0) begin
            y = v0*ONE + x*(v1 - v0);
        end else begin
            pin_x = clamp_range(ht, ONE/4, (3*ONE)/4);
            cx = 2*pin_x - ONE/2;
            cy2 = v0 + v1 + 4*off;
            disc = cx*cx + (ONE - 2*cx)*x;
            if (disc < 0) disc = 0;
            s = floor_sqrt(disc);
            den = s + cx;
            u = (den > 0) ? (x*ONE + den/2) / den : 0;
            u = clamp_range(u, 0, ONE);
            omu = ONE - u;
            y = round_q(omu*omu)*v0 + round_q(omu*u)*cy2 + round_q(u*u)*v1;
        end
        y = clamp_range(y, 0, ONE*ONE);
        return (FB+1)'(round_q(y));
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic queue_req(longint p, longint v0, longint v1, longint ht, longint off);
        t_segment_req r;
        r.position = (FB+1)'(p);
        r.start_value = (FB+1)'(v0);
        r.end_value = (FB+1)'(v1);
        r.handle_time = (FB+1)'(ht);
        r.handle_offset = (FB+2)'(off);
        pending_reqs.push_back(r);
    endtask

    function automatic longint pick_unsigned();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return ONE;
            2: return longint'($urandom_range(0, (1 << (FB+1)) - 1));
            default: return longint'($urandom_range(0, ONE));
        endcase
    endfunction

    task automatic queue_random(int n);
        longint off, ht;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0: off = 0;
                1: off = longint'($urandom_range(0, (1 << (FB+2)) - 1)) - (longint'(1) << (FB+1));
                default: off = longint'($urandom_range(0, 2*ONE)) - ONE;
            endcase
            ht = ($urandom_range(0, 3) == 0) ? ONE/2 : pick_unsigned();
            queue_req(pick_unsigned(), pick_unsigned(), pick_unsigned(), ht, off);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_values.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_reqs.size() != 0 && !stop_sending &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= SW'(pending_reqs.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Prediction on accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            expected_values.push_back(curve_value_of(t_segment_req'(i_s_tdata[RQW-1:0])));
    end

    // Receiver stall control
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            i_m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        logic [FB:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_values.size() == 0) begin
                report_mismatch("unexpected result", longint'(o_m_tdata[FB:0]), -1);
            end else begin
                want = expected_values.pop_front();
                if (o_m_tdata[FB:0] !== want)
                    report_mismatch("curve_value", longint'(o_m_tdata[FB:0]),
                                    longint'(want));
                if (o_m_tdata[MW-1:FB+1] !== '0)
                    report_mismatch("pad bits", longint'(o_m_tdata[MW-1:FB+1]), 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        stop_sending = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_req(0, 0, ONE, ONE/2, 0);
        queue_req(ONE, 0, ONE, ONE/2, 0);
        queue_req(ONE/2, ONE, 0, ONE/2, 0);
        queue_req((1 << (FB+1)) - 1, 0, ONE, ONE/2, 0);
        queue_req(ONE/3, (1 << (FB+1)) - 1, (1 << (FB+1)) - 1, ONE/2, 0);
        queue_req(ONE/3, 0, ONE, ONE/2, 1);
        queue_req(ONE/3, 0, ONE, ONE/2 + 1, 0);
        queue_req(0, ONE/2, ONE/2, 0, ONE);
        queue_req(0, ONE/2, ONE/2, (1 << (FB+1)) - 1, -ONE);
        queue_req(ONE/4, 0, 0, 0, ONE);
        queue_req(ONE/4, ONE, ONE, ONE, -ONE);
        queue_req(ONE/2, ONE/4, ONE/2, ONE/4, ONE/2);
        queue_req(ONE/2, ONE/4, ONE/2, 3*ONE/4, -ONE/2);
        queue_req(ONE, 0, ONE, ONE/4, ONE);
        queue_req(ONE/5, 0, ONE, 3*ONE/4, -ONE);
        queue_req(ONE/2, 0, 0, ONE/2, (longint'(1) << (FB+1)) - 1);
        queue_req(ONE/2, 0, 0, ONE/2, -(longint'(1) << (FB+1)));
        queue_req(ONE/2, 0, ONE, ONE/3, 5);
        queue_req(1, ONE, 0, ONE/2, -3);
        queue_req((1 << (FB+1)) - 1, (1 << (FB+1)) - 1, (1 << (FB+1)) - 1,
                  (1 << (FB+1)) - 1, 0);
        wait_drained();

        queue_random(120);
        wait_drained();

        send_idle_pct = 79;
        queue_random(100);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 79;
        queue_random(100);
        wait_drained();

        send_idle_pct = 37;
        recv_stall_pct = 37;
        queue_random(60);
        @(posedge i_clk);
        hold_off_cycles <= 3*LATENCY;
        queue_random(60);
        wait_drained();

        stop_sending = 1'b1;
        repeat (20) @(posedge i_clk);
        stop_sending = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(60);
        wait_drained();

        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/bcse_pkg.sv
sv/bcse_sqrt_cell.sv
sv/bcse_div_cell.sv
sv/bezier_curve_segment_eval.sv
sv/bcse_checker.sv
tb/bezier_curve_segment_eval_tb.sv
